@@ sv/refcounted_descriptor_cache_macros.svh @@
// ----------------------------------------------------------------------------
// Descriptor cache assertion macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_DESCRIPTOR_CACHE_MACROS_SVH
`define REFCOUNTED_DESCRIPTOR_CACHE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Descriptor cache package
// Shared types, codes and defaults of the reference-counted descriptor cache.
// ----------------------------------------------------------------------------
`default_nettype none
package rdc_pkg;
    localparam int DEF_NUM_KINDS      = 6;
    localparam int DEF_SLOTS_PER_KIND = 32;
    localparam int SLOT_W             = 6;

    localparam logic [1:0] ACT_GET = 2'd0;
    localparam logic [1:0] ACT_ADD = 2'd1;
    localparam logic [1:0] ACT_PUT = 2'd2;
    localparam logic [1:0] ACT_FILL = 2'd3;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_UNDERFLOW = 3'd6;
    localparam logic [2:0] ST_REJECTED = 3'd7;

    localparam logic [1:0] REG_NUM_OPS   = 2'd0;
    localparam logic [1:0] REG_DESC_BYTES = 2'd1;
    localparam logic [1:0] REG_GRAPH_BASE = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  op_kind;
        logic [15:0] desc_index;
        logic [7:0]  region;
        logic        fetch_ok;
        logic [7:0]  fetched_kind;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [32:0] mem_address;
        logic [15:0] ref_count;
    } t_res;

    // Search token passed down the row of cells.
    typedef struct packed {
        logic              vld;
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic [15:0]       hit_refs;
        logic              free;
        logic [SLOT_W-1:0] free_slot;
    } t_tok;

    // Update broadcast to all cells when an action completes.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic              set_valid;
        logic              clr_valid;
        logic [14:0]       idx;
        logic [7:0]        region;
        logic [15:0]       refs;
    } t_wr;
endpackage
`default_nettype wire

@@ sv/rdc_cell.sv @@
// ----------------------------------------------------------------------------
// Descriptor cache cell
// Holds one slot of every bank and updates the passing search token.
// ----------------------------------------------------------------------------
`default_nettype none
module rdc_cell #(
    parameter int NUM_KINDS = rdc_pkg::DEF_NUM_KINDS,
    parameter int KW        = 3,
    parameter int CELL_ID   = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [KW-1:0] i_kind_idx,
    input  wire logic [14:0]   i_idx,
    input  wire logic [7:0]    i_region,
    input  wire rdc_pkg::t_tok i_tok,
    input  wire rdc_pkg::t_wr  i_wr,
    output rdc_pkg::t_tok      o_tok
);
    import rdc_pkg::*;

    logic [NUM_KINDS-1:0] r_valid;
    logic [14:0] r_idx    [NUM_KINDS];
    logic [7:0]  r_region [NUM_KINDS];
    logic [15:0] r_refs   [NUM_KINDS];
    t_tok r_tok, n_tok;
    logic in_range, match, mine;

    assign in_range = 32'(i_kind_idx) < NUM_KINDS;
    assign match = in_range && r_valid[i_kind_idx] && r_idx[i_kind_idx] == i_idx
                   && r_region[i_kind_idx] == i_region;
    assign mine = i_wr.en && in_range && i_wr.slot == SLOT_W'(CELL_ID);

    always_comb begin
        n_tok = i_tok;
        if (match && !i_tok.hit) begin
            n_tok.hit      = 1'b1;
            n_tok.hit_slot = SLOT_W'(CELL_ID);
            n_tok.hit_refs = r_refs[i_kind_idx];
        end
        if (in_range && !r_valid[i_kind_idx] && !i_tok.free) begin
            n_tok.free      = 1'b1;
            n_tok.free_slot = SLOT_W'(CELL_ID);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_valid <= '0;
        end else begin
            r_tok <= n_tok;
            if (mine) begin
                if (i_wr.set_valid) begin
                    r_valid[i_kind_idx] <= 1'b1;
                end else if (i_wr.clr_valid) begin
                    r_valid[i_kind_idx] <= 1'b0;
                end
            end
        end
        if (mine) begin
            r_refs[i_kind_idx] <= i_wr.refs;
            if (i_wr.set_valid) begin
                r_idx[i_kind_idx]    <= i_wr.idx;
                r_region[i_kind_idx] <= i_wr.region;
            end
        end
    end

    assign o_tok = r_tok;
endmodule
`default_nettype wire

@@ sv/refcounted_descriptor_cache.sv @@
// ----------------------------------------------------------------------------
// Reference-counted descriptor cache
// Tag and reference-count store with one bank of slots per operation type.
// ----------------------------------------------------------------------------
// Usage: a word on i_req is taken at a rising edge where start is high and
// busy is low. The block then stays busy while a search token walks down a
// row of SLOTS_PER_KIND cells, one cell per cycle; each cell holds one slot
// of every bank and marks the first matching slot and the first free slot.
// The record address, graph_base + desc_bytes * (ops_per_region * region +
// desc_index), is built in two multiply stages while the token travels.
// When the token leaves the row, the result word and the slot update are
// registered at the same edge, and the cells take the update from that register.
// The result word is on o_res for exactly one cycle, marked by o_strobe;
// the receiver cannot stall. busy falls in the same cycle as o_strobe
// rises, and no new word is taken until then; the walk down the row
// sets how long the block stays busy.
// Reset clears every valid bit, so all slots are free, and loads the
// register defaults (desc_bytes 64). Registers are to be written only while
// the block is idle; pready is always high.
`default_nettype none
module refcounted_descriptor_cache #(
    parameter int NUM_KINDS      = rdc_pkg::DEF_NUM_KINDS,
    parameter int SLOTS_PER_KIND = rdc_pkg::DEF_SLOTS_PER_KIND
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rdc_pkg::t_req i_req,
    output logic               o_strobe,
    output rdc_pkg::t_res      o_res,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rdc_pkg::*;

    localparam int KW = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

    // Configuration registers.
    logic [15:0] r_num_ops;
    logic [7:0]  r_desc_bytes;
    logic [31:0] r_graph_base;

    // The request being worked on.
    t_req  r_req;
    logic  r_busy;
    t_tok  r_tok_in, n_tok_in, r_fin;
    t_tok  tok [SLOTS_PER_KIND+1];
    t_wr   n_wr, r_wr;
    t_res  n_res, r_res;
    logic  r_strobe;
    logic [24:0] r_ord;
    logic [32:0] r_prod;
    logic [32:0] addr;
    logic [KW-1:0] kind_idx;
    logic  accept, ignored;
    logic [15:0] inc_refs, dec_refs;

    assign accept = start && !r_busy;
    assign pready = 1'b1;

    // APB register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ops    <= '0;
            r_desc_bytes <= 8'd64;
            r_graph_base <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_NUM_OPS:    r_num_ops    <= pwdata[15:0];
                REG_DESC_BYTES: r_desc_bytes <= pwdata[7:0];
                REG_GRAPH_BASE: r_graph_base <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_NUM_OPS:    prdata = {16'd0, r_num_ops};
            REG_DESC_BYTES: prdata = {24'd0, r_desc_bytes};
            REG_GRAPH_BASE: prdata = r_graph_base;
            default:        prdata = '0;
        endcase
    end

    // Address pipeline: ordinal first, then scale by the record size.
    always_ff @(posedge i_clk) begin
        r_ord  <= 25'(r_num_ops) * 25'(r_req.region) + 25'(r_req.desc_index[14:0]);
        r_prod <= 33'(r_ord) * 33'(r_desc_bytes);
    end
    assign addr = r_prod + 33'(r_graph_base);

    assign kind_idx = KW'(r_req.op_kind);

    // Fresh token for an accepted word.
    always_comb begin
        n_tok_in     = '0;
        n_tok_in.vld = accept;
    end

    // Row of cells; the token enters at cell 0.
    assign tok[0] = r_tok_in;
    for (genvar g = 0; g < SLOTS_PER_KIND; g++) begin : g_cell
        rdc_cell #(
            .NUM_KINDS(NUM_KINDS),
            .KW       (KW),
            .CELL_ID  (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_kind_idx(kind_idx),
            .i_idx     (r_req.desc_index[14:0]),
            .i_region  (r_req.region),
            .i_tok     (tok[g]),
            .i_wr      (r_wr),
            .o_tok     (tok[g+1])
        );
    end

    assign ignored = r_req.desc_index[15] || (32'(r_req.op_kind) >= NUM_KINDS);
    assign inc_refs = (r_fin.hit_refs == 16'hFFFF) ? r_fin.hit_refs : r_fin.hit_refs + 16'd1;
    assign dec_refs = r_fin.hit_refs - 16'd1;

    // Decide the result and the slot update once the token has left the row.
    always_comb begin
        n_res       = '0;
        n_wr        = '0;
        n_wr.idx    = r_req.desc_index[14:0];
        n_wr.region = r_req.region;
        if (ignored) begin
            n_res.status = ST_IGNORED;
        end else begin
            case (r_req.action)
                ACT_GET, ACT_ADD: begin
                    if (r_fin.hit) begin
                        n_res.status    = ST_HIT;
                        n_res.slot      = 5'(r_fin.hit_slot);
                        n_res.ref_count = inc_refs;
                        n_wr.en   = 1'b1;
                        n_wr.slot = r_fin.hit_slot;
                        n_wr.refs = inc_refs;
                    end else if (r_req.action == ACT_ADD) begin
                        n_res.status = ST_NOTFOUND;
                    end else if (r_fin.free) begin
                        n_res.status      = ST_MISS;
                        n_res.slot        = 5'(r_fin.free_slot);
                        n_res.mem_address = addr;
                    end else begin
                        n_res.status = ST_FULL;
                    end
                end
                ACT_PUT: begin
                    if (!r_fin.hit) begin
                        n_res.status = ST_NOTFOUND;
                    end else if (r_fin.hit_refs == 16'd0) begin
                        n_res.status = ST_UNDERFLOW;
                        n_res.slot   = 5'(r_fin.hit_slot);
                    end else begin
                        n_wr.en   = 1'b1;
                        n_wr.slot = r_fin.hit_slot;
                        n_wr.refs = dec_refs;
                        n_res.slot = 5'(r_fin.hit_slot);
                        if (dec_refs == 16'd0) begin
                            n_wr.clr_valid    = 1'b1;
                            n_res.status      = ST_RELEASED;
                            n_res.mem_address = addr;
                        end else begin
                            n_res.status    = ST_HIT;
                            n_res.ref_count = dec_refs;
                        end
                    end
                end
                default: begin
                    if (r_fin.hit) begin
                        n_res.status    = ST_REJECTED;
                        n_res.slot      = 5'(r_fin.hit_slot);
                        n_res.ref_count = r_fin.hit_refs;
                    end else if (!r_fin.free) begin
                        n_res.status = ST_FULL;
                    end else begin
                        n_res.slot        = 5'(r_fin.free_slot);
                        n_res.mem_address = addr;
                        if (!r_req.fetch_ok || r_req.fetched_kind != {5'd0, r_req.op_kind}) begin
                            n_res.status = ST_REJECTED;
                        end else begin
                            n_res.status    = ST_HIT;
                            n_res.ref_count = 16'd1;
                            n_wr.en        = 1'b1;
                            n_wr.slot      = r_fin.free_slot;
                            n_wr.set_valid = 1'b1;
                            n_wr.refs      = 16'd1;
                        end
                    end
                end
            endcase
        end
        // The update only goes out in the cycle the token leaves the row.
        n_wr.en = n_wr.en && r_fin.vld;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_req <= i_req;
        end
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_fin    <= '0;
            r_tok_in <= '0;
            r_wr     <= '0;
        end else begin
            r_fin    <= tok[SLOTS_PER_KIND];
            r_tok_in <= n_tok_in;
            r_wr     <= n_wr;
            r_strobe <= r_fin.vld;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (r_fin.vld) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;
endmodule
`default_nettype wire

@@ sv/rdc_checker.sv @@
// ----------------------------------------------------------------------------
// Descriptor cache checker
// Port-level checks of the command handshake and result words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "refcounted_descriptor_cache_macros.svh"
module rdc_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_strobe,
    input wire rdc_pkg::t_res o_res
);
    import rdc_pkg::*;

    logic is_ignored, res_clean;

    assign is_ignored = o_strobe && o_res.status == ST_IGNORED;
    assign res_clean  = o_res.slot == 5'd0 && o_res.ref_count == 16'd0
                        && o_res.mem_address == 33'd0;

    `RDC_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    `RDC_ASSERT_NOW(a_idle_at_result, i_clk, i_rst_n, o_strobe, !busy)
    `RDC_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, o_strobe, !o_strobe)
    `RDC_ASSERT_NOW(a_ignored_clean, i_clk, i_rst_n, is_ignored, res_clean)
endmodule

bind refcounted_descriptor_cache rdc_checker u_rdc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_res   (o_res)
);
`default_nettype wire
